// ===== rtl/assert_macros.svh =====
// assertion macros used by the rtl controller
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// same-cycle implication
`define ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);
// next-cycle implication
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);
`else
`define ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg)
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg)
`endif
`endif

// ===== rtl/bzoom_pkg.sv =====
// shared types and constants of the bilinear zoom block
`timescale 1ns / 1ps
package bzoom_pkg;

  localparam int ROW_W      = 10;
  localparam int COL_W      = 10;
  localparam int PIX_W      = 8;
  localparam int SRC_W_W    = 9;
  localparam int SRC_H_W    = 10;
  localparam int OUT_DIM_W  = 11;
  localparam int SCL_W      = 12;
  localparam int STEP_W     = 26;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 26;
  localparam int DIM_W      = 13;
  localparam int WGT_W      = 8;
  localparam int PROD_W     = 2 * WGT_W + 1;
  localparam int ACC_W      = PIX_W + PROD_W;
  localparam int RND_SHIFT  = 2 * WGT_W;

  localparam logic OP_LOAD    = 1'b0;
  localparam logic OP_COMPUTE = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_SRC_WIDTH     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SRC_HEIGHT    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_OUT_WIDTH     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_OUT_HEIGHT    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SCALED_WIDTH  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_SCALED_HEIGHT = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_STEP_X        = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_STEP_Y        = 3'd7;

  localparam logic [SRC_W_W-1:0]   RST_SRC_WIDTH     = 9'd225;
  localparam logic [SRC_H_W-1:0]   RST_SRC_HEIGHT    = 10'd313;
  localparam logic [OUT_DIM_W-1:0] RST_OUT_WIDTH     = 11'd282;
  localparam logic [OUT_DIM_W-1:0] RST_OUT_HEIGHT    = 11'd286;
  localparam logic [SCL_W-1:0]     RST_SCALED_WIDTH  = 12'd282;
  localparam logic [SCL_W-1:0]     RST_SCALED_HEIGHT = 12'd286;
  localparam logic [STEP_W-1:0]    RST_STEP_X        = 26'd52298;
  localparam logic [STEP_W-1:0]    RST_STEP_Y        = 26'd71577;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MAP,
    ST_MUL,
    ST_CLAMP,
    ST_RD0,
    ST_RD1,
    ST_RD2,
    ST_RD3,
    ST_ACC,
    ST_RES
  } state_t;

  typedef struct packed {
    logic       load_we;
    logic       capture;
    logic       map_en;
    logic       mul_en;
    logic       clamp_en;
    logic [1:0] rd_sel;
    logic       acc_en;
    logic [1:0] acc_sel;
    logic       out_load;
  } cmd_t;

  typedef struct packed {
    logic fill;
  } status_t;

endpackage

// ===== rtl/bzoom_in_if.sv =====
// input channel of the bilinear zoom block
`timescale 1ns / 1ps
interface bzoom_in_if;
  logic                       valid;
  logic                       ready;
  logic                       opcode;
  logic [bzoom_pkg::ROW_W-1:0] row;
  logic [bzoom_pkg::COL_W-1:0] col;
  logic [bzoom_pkg::PIX_W-1:0] pixel_in;

  modport source (output valid, opcode, row, col, pixel_in, input ready);
  modport sink (input valid, opcode, row, col, pixel_in, output ready);
endinterface

// ===== rtl/bzoom_out_if.sv =====
// result channel of the bilinear zoom block
`timescale 1ns / 1ps
interface bzoom_out_if;
  logic                       valid;
  logic                       ready;
  logic [bzoom_pkg::PIX_W-1:0] pixel_out;

  modport source (output valid, pixel_out, input ready);
  modport sink (input valid, pixel_out, output ready);
endinterface

// ===== rtl/bzoom_ram.sv =====
// generic single-port ram with registered read
`timescale 1ns / 1ps
module bzoom_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata_r <= mem[addr];
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/bzoom_datapath.sv =====
// datapath: config registers, axis mapping, coordinate products, image memory, accumulator
`timescale 1ns / 1ps
module bzoom_datapath #(
  parameter int SRC_MAX_WIDTH  = 256,
  parameter int SRC_MAX_HEIGHT = 512,
  parameter int FILL_VALUE     = 255,
  parameter int FRAC_BITS      = 16
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [bzoom_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  logic [bzoom_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic [bzoom_pkg::ROW_W-1:0]      in_row,
  input  logic [bzoom_pkg::COL_W-1:0]      in_col,
  input  logic [bzoom_pkg::PIX_W-1:0]      in_pixel,
  input  bzoom_pkg::cmd_t                  cmd,
  output bzoom_pkg::status_t               status,
  output logic [bzoom_pkg::PIX_W-1:0]      out_pixel
);

  localparam int SCL_W = bzoom_pkg::SCL_W;
  localparam int DIM_W = bzoom_pkg::DIM_W;
  localparam int XW    = $clog2(SRC_MAX_WIDTH);
  localparam int YW    = $clog2(SRC_MAX_HEIGHT);
  localparam int DEPTH = SRC_MAX_WIDTH * SRC_MAX_HEIGHT;
  localparam int AW    = $clog2(DEPTH);
  localparam int SX_W  = SCL_W + bzoom_pkg::STEP_W + 1;
  localparam int IW    = SX_W - FRAC_BITS;
  localparam int WW    = bzoom_pkg::WGT_W;
  localparam int ACC_W = bzoom_pkg::ACC_W;
  localparam logic [SX_W-1:0]  HALF     = SX_W'(1) << (FRAC_BITS - 1);
  localparam logic [ACC_W:0]   RND_HALF = (ACC_W + 1)'(1) << (bzoom_pkg::RND_SHIFT - 1);
  localparam logic [DIM_W-1:0] MAX_W    = DIM_W'(SRC_MAX_WIDTH);
  localparam logic [DIM_W-1:0] MAX_H    = DIM_W'(SRC_MAX_HEIGHT);

  typedef struct packed {
    logic             ok;
    logic [SCL_W-1:0] idx;
  } axis_t;

  // output index to scaled index, centred by crop or pad
  function automatic axis_t map_axis(input logic [bzoom_pkg::ROW_W-1:0] idx,
                                     input logic [bzoom_pkg::OUT_DIM_W-1:0] osz,
                                     input logic [SCL_W-1:0] ssz);
    logic signed [SCL_W+1:0] diff;
    logic signed [SCL_W+1:0] off;
    logic signed [SCL_W+1:0] pos;
    axis_t                   res;
    diff    = $signed({2'b00, ssz}) - $signed({3'b000, osz});
    off     = (diff + $signed({{(SCL_W + 1){1'b0}}, diff[SCL_W+1]})) >>> 1;
    pos     = $signed({4'b0000, idx}) + off;
    res.ok  = ({1'b0, idx} < osz) && (pos[SCL_W+1:SCL_W] == 2'b00) && (pos[SCL_W-1:0] < ssz);
    res.idx = pos[SCL_W-1:0];
    return res;
  endfunction

  // configuration registers
  logic [bzoom_pkg::SRC_W_W-1:0]   src_width_r;
  logic [bzoom_pkg::SRC_H_W-1:0]   src_height_r;
  logic [bzoom_pkg::OUT_DIM_W-1:0] out_width_r;
  logic [bzoom_pkg::OUT_DIM_W-1:0] out_height_r;
  logic [SCL_W-1:0]                scaled_width_r;
  logic [SCL_W-1:0]                scaled_height_r;
  logic [bzoom_pkg::STEP_W-1:0]    step_x_r;
  logic [bzoom_pkg::STEP_W-1:0]    step_y_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_width_r     <= bzoom_pkg::RST_SRC_WIDTH;
      src_height_r    <= bzoom_pkg::RST_SRC_HEIGHT;
      out_width_r     <= bzoom_pkg::RST_OUT_WIDTH;
      out_height_r    <= bzoom_pkg::RST_OUT_HEIGHT;
      scaled_width_r  <= bzoom_pkg::RST_SCALED_WIDTH;
      scaled_height_r <= bzoom_pkg::RST_SCALED_HEIGHT;
      step_x_r        <= bzoom_pkg::RST_STEP_X;
      step_y_r        <= bzoom_pkg::RST_STEP_Y;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        bzoom_pkg::REG_SRC_WIDTH:     src_width_r     <= cfg_data[bzoom_pkg::SRC_W_W-1:0];
        bzoom_pkg::REG_SRC_HEIGHT:    src_height_r    <= cfg_data[bzoom_pkg::SRC_H_W-1:0];
        bzoom_pkg::REG_OUT_WIDTH:     out_width_r     <= cfg_data[bzoom_pkg::OUT_DIM_W-1:0];
        bzoom_pkg::REG_OUT_HEIGHT:    out_height_r    <= cfg_data[bzoom_pkg::OUT_DIM_W-1:0];
        bzoom_pkg::REG_SCALED_WIDTH:  scaled_width_r  <= cfg_data[SCL_W-1:0];
        bzoom_pkg::REG_SCALED_HEIGHT: scaled_height_r <= cfg_data[SCL_W-1:0];
        bzoom_pkg::REG_STEP_X:        step_x_r        <= cfg_data[bzoom_pkg::STEP_W-1:0];
        bzoom_pkg::REG_STEP_Y:        step_y_r        <= cfg_data[bzoom_pkg::STEP_W-1:0];
        default: ;
      endcase
    end
  end

  // request capture and axis mapping
  logic [bzoom_pkg::ROW_W-1:0] row_r;
  logic [bzoom_pkg::COL_W-1:0] col_r;
  logic [SCL_W-1:0]            i_r;
  logic [SCL_W-1:0]            j_r;
  logic [DIM_W-1:0]            w_sat_r;
  logic [DIM_W-1:0]            h_sat_r;
  logic                        fill_r;
  axis_t                       map_row;
  axis_t                       map_col;

  always_comb begin
    map_row = map_axis(row_r, out_height_r, scaled_height_r);
    map_col = map_axis(col_r, out_width_r, scaled_width_r);
  end

  // source coordinates
  logic [SX_W-1:0] sx_r;
  logic [SX_W-1:0] sy_r;

  // neighbour clamp and weights
  logic [IW-1:0]     x0;
  logic [IW-1:0]     y0;
  logic [IW-1:0]     xn;
  logic [IW-1:0]     yn;
  logic [IW-1:0]     x1;
  logic [IW-1:0]     y1;
  logic [WW-1:0]     wx;
  logic [WW-1:0]     wy;
  logic [WW:0]       wx_inv;
  logic [WW:0]       wy_inv;
  logic              clamp_fill;
  logic [XW-1:0]     x0_r;
  logic [XW-1:0]     x1_r;
  logic [YW-1:0]     y0_r;
  logic [YW-1:0]     y1_r;
  logic [bzoom_pkg::PROD_W-1:0] wp_r [4];

  always_comb begin
    x0         = sx_r[SX_W-1:FRAC_BITS];
    y0         = sy_r[SX_W-1:FRAC_BITS];
    xn         = x0 + IW'(1);
    yn         = y0 + IW'(1);
    x1         = (xn >= IW'(w_sat_r)) ? IW'(w_sat_r) - IW'(1) : xn;
    y1         = (yn >= IW'(h_sat_r)) ? IW'(h_sat_r) - IW'(1) : yn;
    wx         = sx_r[FRAC_BITS-1 -: WW];
    wy         = sy_r[FRAC_BITS-1 -: WW];
    wx_inv     = (WW + 1)'(1 << WW) - {1'b0, wx};
    wy_inv     = (WW + 1)'(1 << WW) - {1'b0, wy};
    clamp_fill = (x0 >= IW'(w_sat_r)) || (y0 >= IW'(h_sat_r));
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      row_r <= in_row;
      col_r <= in_col;
    end
    if (cmd.map_en) begin
      i_r     <= map_row.idx;
      j_r     <= map_col.idx;
      fill_r  <= !(map_row.ok && map_col.ok);
      w_sat_r <= (DIM_W'(src_width_r) > MAX_W) ? MAX_W : DIM_W'(src_width_r);
      h_sat_r <= (DIM_W'(src_height_r) > MAX_H) ? MAX_H : DIM_W'(src_height_r);
    end
    if (cmd.mul_en) begin
      sx_r <= SX_W'(j_r) * SX_W'(step_x_r) + HALF;
      sy_r <= SX_W'(i_r) * SX_W'(step_y_r) + HALF;
    end
    if (cmd.clamp_en) begin
      fill_r <= fill_r | clamp_fill;
      x0_r   <= x0[XW-1:0];
      x1_r   <= x1[XW-1:0];
      y0_r   <= y0[YW-1:0];
      y1_r   <= y1[YW-1:0];
      wp_r[0] <= bzoom_pkg::PROD_W'(wy_inv * wx_inv);
      wp_r[1] <= bzoom_pkg::PROD_W'(wy_inv * {1'b0, wx});
      wp_r[2] <= bzoom_pkg::PROD_W'({1'b0, wy} * wx_inv);
      wp_r[3] <= bzoom_pkg::PROD_W'({1'b0, wy} * {1'b0, wx});
    end
  end

  // image memory, shared by loads and neighbour reads
  logic                        ld_in_range;
  logic                        ram_we;
  logic [AW-1:0]               ld_addr;
  logic [AW-1:0]               rd_addr;
  logic [AW-1:0]               ram_addr;
  logic [XW-1:0]               rd_x;
  logic [YW-1:0]               rd_y;
  logic [bzoom_pkg::PIX_W-1:0] ram_rdata;

  always_comb begin
    ld_in_range = (DIM_W'(in_row) < MAX_H) && (DIM_W'(in_col) < MAX_W);
    ram_we      = cmd.load_we && ld_in_range;
    ld_addr     = AW'(in_row) * AW'(SRC_MAX_WIDTH) + AW'(in_col);
    rd_y        = cmd.rd_sel[1] ? y1_r : y0_r;
    rd_x        = cmd.rd_sel[0] ? x1_r : x0_r;
    rd_addr     = AW'(rd_y) * AW'(SRC_MAX_WIDTH) + AW'(rd_x);
    ram_addr    = ram_we ? ld_addr : rd_addr;
  end

  bzoom_ram #(
    .WIDTH (bzoom_pkg::PIX_W),
    .DEPTH (DEPTH)
  ) u_image (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (in_pixel),
    .rdata (ram_rdata)
  );

  // weighted sum and rounding
  logic [ACC_W-1:0]            acc_r;
  logic [ACC_W:0]              rnd_sum;
  logic [ACC_W-bzoom_pkg::RND_SHIFT:0] rnd_val;
  logic [bzoom_pkg::PIX_W-1:0] pix_val;
  logic [bzoom_pkg::PIX_W-1:0] out_pixel_r;

  always_comb begin
    rnd_sum = {1'b0, acc_r} + RND_HALF;
    rnd_val = rnd_sum[ACC_W:bzoom_pkg::RND_SHIFT];
    pix_val = (rnd_val > (ACC_W - bzoom_pkg::RND_SHIFT + 1)'(255)) ? 8'd255
                                                                   : rnd_val[7:0];
  end

  always_ff @(posedge clk) begin
    if (cmd.clamp_en) begin
      acc_r <= '0;
    end else if (cmd.acc_en) begin
      acc_r <= acc_r + ACC_W'(ACC_W'(ram_rdata) * ACC_W'(wp_r[cmd.acc_sel]));
    end
    if (cmd.out_load) begin
      out_pixel_r <= fill_r ? bzoom_pkg::PIX_W'(FILL_VALUE) : pix_val;
    end
  end

  assign status.fill = fill_r | clamp_fill;
  assign out_pixel   = out_pixel_r;

endmodule

// ===== rtl/bzoom_ctrl.sv =====
// controller: sequences one transaction through the datapath and holds the result valid
`timescale 1ns / 1ps
`include "assert_macros.svh"
module bzoom_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_opcode,
  output logic               in_ready,
  output logic               out_valid,
  input  logic               out_ready,
  input  bzoom_pkg::status_t status,
  output bzoom_pkg::cmd_t    cmd
);

  bzoom_pkg::state_t state_r;
  bzoom_pkg::state_t state_nxt;
  logic              out_valid_r;
  logic              out_valid_nxt;
  logic              res_free;

  assign res_free = !out_valid_r || out_ready;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      bzoom_pkg::ST_IDLE: begin
        if (in_valid && in_opcode == bzoom_pkg::OP_COMPUTE) begin
          state_nxt = bzoom_pkg::ST_MAP;
        end
      end
      bzoom_pkg::ST_MAP:   state_nxt = bzoom_pkg::ST_MUL;
      bzoom_pkg::ST_MUL:   state_nxt = bzoom_pkg::ST_CLAMP;
      bzoom_pkg::ST_CLAMP: begin
        state_nxt = status.fill ? bzoom_pkg::ST_RES : bzoom_pkg::ST_RD0;
      end
      bzoom_pkg::ST_RD0:   state_nxt = bzoom_pkg::ST_RD1;
      bzoom_pkg::ST_RD1:   state_nxt = bzoom_pkg::ST_RD2;
      bzoom_pkg::ST_RD2:   state_nxt = bzoom_pkg::ST_RD3;
      bzoom_pkg::ST_RD3:   state_nxt = bzoom_pkg::ST_ACC;
      bzoom_pkg::ST_ACC:   state_nxt = bzoom_pkg::ST_RES;
      bzoom_pkg::ST_RES: begin
        if (res_free) begin
          state_nxt = bzoom_pkg::ST_IDLE;
        end
      end
      default: state_nxt = bzoom_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state_r)
      bzoom_pkg::ST_IDLE: begin
        in_ready    = 1'b1;
        cmd.capture = in_valid && in_opcode == bzoom_pkg::OP_COMPUTE;
        cmd.load_we = in_valid && in_opcode == bzoom_pkg::OP_LOAD;
      end
      bzoom_pkg::ST_MAP:   cmd.map_en = 1'b1;
      bzoom_pkg::ST_MUL:   cmd.mul_en = 1'b1;
      bzoom_pkg::ST_CLAMP: cmd.clamp_en = 1'b1;
      bzoom_pkg::ST_RD0:   cmd.rd_sel = 2'd0;
      bzoom_pkg::ST_RD1: begin
        cmd.rd_sel  = 2'd1;
        cmd.acc_en  = 1'b1;
        cmd.acc_sel = 2'd0;
      end
      bzoom_pkg::ST_RD2: begin
        cmd.rd_sel  = 2'd2;
        cmd.acc_en  = 1'b1;
        cmd.acc_sel = 2'd1;
      end
      bzoom_pkg::ST_RD3: begin
        cmd.rd_sel  = 2'd3;
        cmd.acc_en  = 1'b1;
        cmd.acc_sel = 2'd2;
      end
      bzoom_pkg::ST_ACC: begin
        cmd.acc_en  = 1'b1;
        cmd.acc_sel = 2'd3;
      end
      bzoom_pkg::ST_RES:   cmd.out_load = res_free;
      default: ;
    endcase
  end

  always_comb begin
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= bzoom_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

  `ASSERT_NEXT(a_compute_starts, clk, rst_n, state_r == bzoom_pkg::ST_IDLE && in_valid && in_opcode == bzoom_pkg::OP_COMPUTE, state_r == bzoom_pkg::ST_MAP, "compute transaction did not start mapping")
  `ASSERT_NEXT(a_result_posted, clk, rst_n, state_r == bzoom_pkg::ST_RES && cmd.out_load, out_valid_r && state_r == bzoom_pkg::ST_IDLE, "result not posted after load")
  `ASSERT_IMPL(a_reads_in_range, clk, rst_n, state_r == bzoom_pkg::ST_RD0, !status.fill, "memory read started for a fill pixel")

endmodule

// ===== rtl/bilinear_image_zoom.sv =====
// top level of the bilinear image zoom block
// load transaction: the pixel is written at the edge that accepts it, no result
// compute transaction: map, multiply, clamp, four serial reads of the single-port image ram
// and accumulate (a fill pixel skips both), result load when the result register is free;
// the result register frees the input side while a result waits to be taken
// reset: controller idle, result register empty, config registers to defaults; image not cleared
`timescale 1ns / 1ps
module bilinear_image_zoom #(
  parameter int SRC_MAX_WIDTH  = 256,
  parameter int SRC_MAX_HEIGHT = 512,
  parameter int FILL_VALUE     = 255,
  parameter int FRAC_BITS      = 16
) (
  input  logic                             clk,
  input  logic                             rst_n,
  bzoom_in_if.sink                         in_ch,
  bzoom_out_if.source                      out_ch,
  input  logic                             cfg_we,
  input  logic [bzoom_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  logic [bzoom_pkg::CFG_DATA_W-1:0] cfg_data
);

  bzoom_pkg::cmd_t    cmd;
  bzoom_pkg::status_t status;

  bzoom_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_opcode (in_ch.opcode),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .status    (status),
    .cmd       (cmd)
  );

  bzoom_datapath #(
    .SRC_MAX_WIDTH  (SRC_MAX_WIDTH),
    .SRC_MAX_HEIGHT (SRC_MAX_HEIGHT),
    .FILL_VALUE     (FILL_VALUE),
    .FRAC_BITS      (FRAC_BITS)
  ) u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_data  (cfg_data),
    .in_row    (in_ch.row),
    .in_col    (in_ch.col),
    .in_pixel  (in_ch.pixel_in),
    .cmd       (cmd),
    .status    (status),
    .out_pixel (out_ch.pixel_out)
  );

endmodule

// ===== sim/tb_bzoom_pkg.sv =====
// testbench types and the source tap mapping of the bilinear zoom block
`timescale 1ns / 1ps
package tb_bzoom_pkg;
  import bzoom_pkg::*;

  localparam int SRC_MAX_WIDTH  = 256;
  localparam int SRC_MAX_HEIGHT = 512;
  localparam int FILL_VALUE     = 255;
  localparam int FRAC_BITS      = 16;
  localparam int IMAGE_DEPTH    = SRC_MAX_WIDTH * SRC_MAX_HEIGHT;

  typedef struct packed {
    logic [SRC_W_W-1:0]   src_w;
    logic [SRC_H_W-1:0]   src_h;
    logic [OUT_DIM_W-1:0] out_w;
    logic [OUT_DIM_W-1:0] out_h;
    logic [SCL_W-1:0]     scl_w;
    logic [SCL_W-1:0]     scl_h;
    logic [STEP_W-1:0]    step_x;
    logic [STEP_W-1:0]    step_y;
  } zoom_cfg_t;

  typedef struct {
    bit          fill;
    int unsigned x0;
    int unsigned x1;
    int unsigned y0;
    int unsigned y1;
    int unsigned wx;
    int unsigned wy;
  } zoom_taps_t;

  // centring offset truncates toward zero, so odd differences round toward the middle
  function automatic bit window_to_scaled(input int unsigned idx, input int unsigned out_size,
                                          input int unsigned scl_size,
                                          output int unsigned scl_idx);
    int off;
    int pos;
    scl_idx = 0;
    off = (int'(scl_size) - int'(out_size)) / 2;
    pos = int'(idx) + off;
    if (idx >= out_size || pos < 0 || pos >= int'(scl_size)) return 1'b0;
    scl_idx = unsigned'(pos);
    return 1'b1;
  endfunction

  function automatic zoom_taps_t locate_taps(input zoom_cfg_t cfg, input int unsigned row,
                                             input int unsigned col);
    zoom_taps_t t;
    int unsigned i;
    int unsigned j;
    int unsigned w;
    int unsigned h;
    longint unsigned sx;
    longint unsigned sy;
    longint unsigned x0;
    longint unsigned y0;
    t = '{1'b1, 0, 0, 0, 0, 0, 0};
    if (!window_to_scaled(row, cfg.out_h, cfg.scl_h, i)) return t;
    if (!window_to_scaled(col, cfg.out_w, cfg.scl_w, j)) return t;
    w = (cfg.src_w > SRC_MAX_WIDTH) ? SRC_MAX_WIDTH : cfg.src_w;
    h = (cfg.src_h > SRC_MAX_HEIGHT) ? SRC_MAX_HEIGHT : cfg.src_h;
    sx = 64'(j) * 64'(cfg.step_x) + (64'd1 << (FRAC_BITS - 1));
    sy = 64'(i) * 64'(cfg.step_y) + (64'd1 << (FRAC_BITS - 1));
    x0 = sx >> FRAC_BITS;
    y0 = sy >> FRAC_BITS;
    if (x0 >= w || y0 >= h) return t;
    t.fill = 1'b0;
    t.x0 = 32'(x0);
    t.y0 = 32'(y0);
    t.x1 = (x0 + 1 >= w) ? w - 1 : 32'(x0 + 1);
    t.y1 = (y0 + 1 >= h) ? h - 1 : 32'(y0 + 1);
    t.wx = 32'((sx & ((64'd1 << FRAC_BITS) - 1)) >> (FRAC_BITS - 8));
    t.wy = 32'((sy & ((64'd1 << FRAC_BITS) - 1)) >> (FRAC_BITS - 8));
    return t;
  endfunction

endpackage

// ===== sim/bzoom_checker.sv =====
// checker that predicts every output pixel of the zoom block and compares it
`timescale 1ns / 1ps
module bzoom_checker
  import bzoom_pkg::*;
  import tb_bzoom_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  bzoom_in_if                   in_mon,
  bzoom_out_if                  out_mon,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_idx,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output int                    error_count,
  output int                    outstanding
);

  zoom_cfg_t  regs_q;
  logic [PIX_W-1:0] image_q [IMAGE_DEPTH];
  logic [PIX_W-1:0] expected_pixels [$];

  initial begin
    error_count = 0;
    outstanding = 0;
  end

  function automatic logic [PIX_W-1:0] zoom_pixel(input logic [ROW_W-1:0] r,
                                                  input logic [COL_W-1:0] c);
    zoom_taps_t t;
    longint unsigned p00;
    longint unsigned p01;
    longint unsigned p10;
    longint unsigned p11;
    longint unsigned acc;
    t = locate_taps(regs_q, r, c);
    if (t.fill) return PIX_W'(FILL_VALUE);
    p00 = image_q[t.y0 * SRC_MAX_WIDTH + t.x0];
    p01 = image_q[t.y0 * SRC_MAX_WIDTH + t.x1];
    p10 = image_q[t.y1 * SRC_MAX_WIDTH + t.x0];
    p11 = image_q[t.y1 * SRC_MAX_WIDTH + t.x1];
    acc = p00 * (256 - t.wy) * (256 - t.wx) + p01 * (256 - t.wy) * t.wx
        + p10 * t.wy * (256 - t.wx) + p11 * t.wy * t.wx;
    acc = (acc + 32768) >> 16;
    return (acc > 255) ? 8'd255 : acc[PIX_W-1:0];
  endfunction

  task automatic note_mismatch(input string what, input int exp_val, input logic [PIX_W-1:0] act);
    error_count++;
    if (error_count <= 10)
      $display("%0t mismatch (%s): expected %0d, got %0d", $realtime, what, exp_val, act);
  endtask

  always @(posedge clk) begin
    logic [PIX_W-1:0] exp_pix;
    if (!rst_n) begin
      regs_q = '{RST_SRC_WIDTH, RST_SRC_HEIGHT, RST_OUT_WIDTH, RST_OUT_HEIGHT,
                 RST_SCALED_WIDTH, RST_SCALED_HEIGHT, RST_STEP_X, RST_STEP_Y};
      expected_pixels.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_idx)
          REG_SRC_WIDTH:     regs_q.src_w  = cfg_data[SRC_W_W-1:0];
          REG_SRC_HEIGHT:    regs_q.src_h  = cfg_data[SRC_H_W-1:0];
          REG_OUT_WIDTH:     regs_q.out_w  = cfg_data[OUT_DIM_W-1:0];
          REG_OUT_HEIGHT:    regs_q.out_h  = cfg_data[OUT_DIM_W-1:0];
          REG_SCALED_WIDTH:  regs_q.scl_w  = cfg_data[SCL_W-1:0];
          REG_SCALED_HEIGHT: regs_q.scl_h  = cfg_data[SCL_W-1:0];
          REG_STEP_X:        regs_q.step_x = cfg_data[STEP_W-1:0];
          REG_STEP_Y:        regs_q.step_y = cfg_data[STEP_W-1:0];
          default: ;
        endcase
      end
      if (in_mon.valid && in_mon.ready) begin
        if (in_mon.opcode == OP_LOAD) begin
          if (in_mon.row < SRC_MAX_HEIGHT && in_mon.col < SRC_MAX_WIDTH)
            image_q[in_mon.row * SRC_MAX_WIDTH + in_mon.col] = in_mon.pixel_in;
        end else begin
          expected_pixels.push_back(zoom_pixel(in_mon.row, in_mon.col));
        end
      end
      if (out_mon.valid && out_mon.ready) begin
        if (expected_pixels.size() == 0) begin
          note_mismatch("unexpected transaction", -1, out_mon.pixel_out);
        end else begin
          exp_pix = expected_pixels.pop_front();
          if (out_mon.pixel_out !== exp_pix)
            note_mismatch("pixel_out", exp_pix, out_mon.pixel_out);
        end
      end
    end
    outstanding = expected_pixels.size();
  end

endmodule

// ===== sim/tb_bilinear_image_zoom.sv =====
// testbench top: stimulus, configuration phases and verdict for the zoom block
`timescale 1ns / 1ps
module tb_bilinear_image_zoom;
  import bzoom_pkg::*;
  import tb_bzoom_pkg::*;

  localparam int ITEM_TARGET = 1950;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_data;
  int                    chk_errors;
  int                    chk_pending;
  bit                    calm = 1'b1;
  bit                    loaded [IMAGE_DEPTH];
  int                    items_sent = 0;
  zoom_cfg_t             cur;

  bzoom_in_if  in_ch ();
  bzoom_out_if out_ch ();

  bilinear_image_zoom #(
    .SRC_MAX_WIDTH (SRC_MAX_WIDTH),
    .SRC_MAX_HEIGHT(SRC_MAX_HEIGHT),
    .FILL_VALUE    (FILL_VALUE),
    .FRAC_BITS     (FRAC_BITS)
  ) uut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .cfg_we  (cfg_we),
    .cfg_idx (cfg_idx),
    .cfg_data(cfg_data)
  );

  bzoom_checker chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_mon     (in_ch),
    .out_mon    (out_ch),
    .cfg_we     (cfg_we),
    .cfg_idx    (cfg_idx),
    .cfg_data   (cfg_data),
    .error_count(chk_errors),
    .outstanding(chk_pending)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  initial begin
    #4_000_000;
    $display("Regression FAIL");
    $finish;
  end

  // mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  initial begin
    int hold;
    hold = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold > 0) begin
        out_ch.ready <= 1'b0;
        hold--;
      end else begin
        out_ch.ready <= 1'b1;
        if ($urandom_range(0, 4) == 0) hold = pick_gap();
      end
    end
  end

  function automatic zoom_cfg_t make_cfg(input int unsigned sw, sh, ow, oh, scw, sch,
                                         input int unsigned stx, sty);
    zoom_cfg_t c;
    c.src_w  = SRC_W_W'(sw);
    c.src_h  = SRC_H_W'(sh);
    c.out_w  = OUT_DIM_W'(ow);
    c.out_h  = OUT_DIM_W'(oh);
    c.scl_w  = SCL_W'(scw);
    c.scl_h  = SCL_W'(sch);
    c.step_x = STEP_W'(stx);
    c.step_y = STEP_W'(sty);
    return c;
  endfunction

  function automatic zoom_cfg_t random_zoom_cfg();
    int unsigned mode;
    int unsigned sw, sh, ow, oh, scw, sch, stx, sty;
    mode = $urandom_range(0, 9);
    if (mode < 7) begin
      sw  = $urandom_range(1, 16);
      sh  = $urandom_range(1, 16);
      ow  = $urandom_range(1, 48);
      oh  = $urandom_range(1, 48);
      scw = ($urandom_range(0, 19) == 0) ? 0 : $urandom_range(1, 64);
      sch = ($urandom_range(0, 19) == 0) ? 0 : $urandom_range(1, 64);
      stx = (scw != 0) ? (sw << 16) / scw : $urandom_range(0, 1 << 20);
      sty = (sch != 0) ? (sh << 16) / sch : $urandom_range(0, 1 << 20);
      if ($urandom_range(0, 1) == 0) stx += $urandom_range(0, 255);
      if ($urandom_range(0, 1) == 0) sty += $urandom_range(0, 255);
    end else if (mode == 7) begin
      sw  = $urandom_range(200, 511);
      sh  = $urandom_range(400, 1023);
      ow  = $urandom_range(512, 1024);
      oh  = $urandom_range(512, 1024);
      scw = $urandom_range(0, 4095);
      sch = $urandom_range(0, 4095);
      stx = $urandom_range(0, 26'h3FFFFFF);
      sty = $urandom_range(0, 26'h3FFFFFF);
    end else if (mode == 8) begin
      sw  = $urandom_range(0, 1) ? 256 : 1;
      sh  = $urandom_range(0, 1) ? 512 : 1;
      ow  = $urandom_range(0, 1) ? 1024 : 1;
      oh  = $urandom_range(0, 1) ? 1024 : 1;
      scw = $urandom_range(0, 1) ? 4095 : 0;
      sch = $urandom_range(0, 1) ? 4095 : 0;
      stx = $urandom_range(0, 1) ? 26'h3FFFFFF : 0;
      sty = $urandom_range(0, 1) ? 26'h3FFFFFF : 0;
    end else begin
      sw  = $urandom_range(1, 511);
      sh  = $urandom_range(1, 1023);
      ow  = $urandom_range(1, 1024);
      oh  = $urandom_range(1, 1024);
      scw = $urandom_range(0, 4095);
      sch = $urandom_range(0, 4095);
      stx = $urandom_range(0, 26'h3FFFFFF);
      sty = $urandom_range(0, 26'h3FFFFFF);
    end
    return make_cfg(sw, sh, ow, oh, scw, sch, stx, sty);
  endfunction

  function automatic int unsigned window_pick(input int unsigned size);
    int unsigned lim;
    if ($urandom_range(0, 9) == 0) return $urandom_range(0, 1023);
    lim = (size == 0) ? 0 : size - 1;
    if (lim > 1023) lim = 1023;
    return $urandom_range(0, lim);
  endfunction

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= data;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic apply_cfg(input zoom_cfg_t c);
    cfg_write(REG_SRC_WIDTH,     CFG_DATA_W'(c.src_w));
    cfg_write(REG_SRC_HEIGHT,    CFG_DATA_W'(c.src_h));
    cfg_write(REG_OUT_WIDTH,     CFG_DATA_W'(c.out_w));
    cfg_write(REG_OUT_HEIGHT,    CFG_DATA_W'(c.out_h));
    cfg_write(REG_SCALED_WIDTH,  CFG_DATA_W'(c.scl_w));
    cfg_write(REG_SCALED_HEIGHT, CFG_DATA_W'(c.scl_h));
    cfg_write(REG_STEP_X,        CFG_DATA_W'(c.step_x));
    cfg_write(REG_STEP_Y,        CFG_DATA_W'(c.step_y));
    cur = c;
  endtask

  task automatic send_item(input logic op, input int unsigned r, input int unsigned c,
                           input int unsigned pix);
    int gap;
    gap = pick_gap();
    @(negedge clk);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid    <= 1'b1;
    in_ch.opcode   <= op;
    in_ch.row      <= r[ROW_W-1:0];
    in_ch.col      <= c[COL_W-1:0];
    in_ch.pixel_in <= pix[PIX_W-1:0];
    do @(posedge clk); while (!in_ch.ready);
    if (op == OP_LOAD && r[ROW_W-1:0] < SRC_MAX_HEIGHT && c[COL_W-1:0] < SRC_MAX_WIDTH) begin
      loaded[r * SRC_MAX_WIDTH + c] = 1'b1;
    end
    items_sent++;
  endtask

  task automatic ensure_loaded(input int unsigned y, input int unsigned x);
    if (!loaded[y * SRC_MAX_WIDTH + x]) send_item(OP_LOAD, y, x, $urandom_range(0, 255));
  endtask

  // load whatever source pixels the compute would read, then issue it
  task automatic compute_item(input int unsigned r, input int unsigned c);
    zoom_taps_t t;
    t = locate_taps(cur, r, c);
    if (!t.fill) begin
      ensure_loaded(t.y0, t.x0);
      ensure_loaded(t.y0, t.x1);
      ensure_loaded(t.y1, t.x0);
      ensure_loaded(t.y1, t.x1);
    end
    send_item(OP_COMPUTE, r, c, $urandom_range(0, 255));
  endtask

  task automatic random_item();
    int unsigned k;
    int unsigned hmax;
    int unsigned wmax;
    k = $urandom_range(0, 99);
    hmax = (cur.src_h > SRC_MAX_HEIGHT) ? SRC_MAX_HEIGHT : cur.src_h;
    wmax = (cur.src_w > SRC_MAX_WIDTH) ? SRC_MAX_WIDTH : cur.src_w;
    if (k < 70) begin
      compute_item(window_pick(cur.out_h), window_pick(cur.out_w));
    end else if (k < 90 && hmax > 0 && wmax > 0) begin
      send_item(OP_LOAD, $urandom_range(0, hmax - 1), $urandom_range(0, wmax - 1),
                $urandom_range(0, 255));
    end else begin
      send_item(OP_LOAD, $urandom_range(0, 1023), $urandom_range(0, 1023),
                $urandom_range(0, 255));
    end
  endtask

  // drain all outstanding results, then let the pipeline go quiet
  task automatic settle();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (chk_pending != 0) @(negedge clk);
    repeat (12) @(negedge clk);
  endtask

  initial begin
    in_ch.valid    = 1'b0;
    in_ch.opcode   = OP_LOAD;
    in_ch.row      = '0;
    in_ch.col      = '0;
    in_ch.pixel_in = '0;
    cfg_we         = 1'b0;
    cfg_idx        = '0;
    cfg_data       = '0;
    cur = make_cfg(RST_SRC_WIDTH, RST_SRC_HEIGHT, RST_OUT_WIDTH, RST_OUT_HEIGHT,
                   RST_SCALED_WIDTH, RST_SCALED_HEIGHT, RST_STEP_X, RST_STEP_Y);
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;

    // reset settings, field extremes and loads outside the image
    send_item(OP_LOAD, 1023, 1023, 255);
    send_item(OP_LOAD, 511, 256, 0);
    send_item(OP_LOAD, 512, 255, 255);
    send_item(OP_LOAD, 511, 255, 0);
    send_item(OP_LOAD, 0, 0, 255);
    send_item(OP_LOAD, 0, 1, 0);
    send_item(OP_LOAD, 1, 0, 0);
    send_item(OP_LOAD, 1, 1, 255);
    compute_item(0, 0);
    compute_item(285, 281);
    compute_item(286, 0);
    compute_item(1023, 1023);

    // padding with an odd size difference
    settle();
    apply_cfg(make_cfg(4, 4, 10, 10, 5, 5, 52429, 52429));
    compute_item(0, 0);
    compute_item(6, 6);
    compute_item(7, 7);
    compute_item(1, 2);

    // cropping
    settle();
    apply_cfg(make_cfg(2, 2, 2, 2, 8, 8, 16384, 16384));
    compute_item(0, 0);
    compute_item(1, 1);

    // oversized source registers, edge clamp and coordinates beyond the source
    settle();
    apply_cfg(make_cfg(511, 1023, 3, 3, 3, 3, 255 << 16, 511 << 16));
    compute_item(0, 0);
    compute_item(1, 1);
    compute_item(2, 2);

    // empty scaled image
    settle();
    apply_cfg(make_cfg(2, 2, 1, 1, 0, 0, 0, 0));
    compute_item(0, 0);

    while (items_sent < ITEM_TARGET) begin
      settle();
      apply_cfg(random_zoom_cfg());
      calm = ($urandom_range(0, 3) == 0);
      repeat ($urandom_range(20, 80)) begin
        if (items_sent < ITEM_TARGET) random_item();
      end
    end

    settle();
    if (chk_errors == 0 && chk_pending == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/bzoom_pkg.sv
rtl/bzoom_in_if.sv
rtl/bzoom_out_if.sv
rtl/bzoom_ram.sv
rtl/bzoom_datapath.sv
rtl/bzoom_ctrl.sv
rtl/bilinear_image_zoom.sv
sim/tb_bzoom_pkg.sv
sim/bzoom_checker.sv
sim/tb_bilinear_image_zoom.sv
